// File: src/swmm_pkg.sv
package swmm_pkg;

	// default sizing of the block
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// fixed field widths of the ports
	localparam int PORT_W = 32;
	localparam int SUM_W  = 64;
	localparam int CFG_W  = 7;

	// window size after reset
	localparam logic [CFG_W-1:0] WS_RESET = 7'd1;

endpackage

// File: src/swmm_cell.sv
// one cell of the window chain: holds min and max of the newest samples up to its depth
module swmm_cell #(
	parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
	parameter int IW          = 6,
	parameter int POS         = 0
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] prev_min,
	input  logic signed [SAMPLE_BITS-1:0] prev_max,
	input  logic        [IW-1:0]          tap_idx,
	output logic signed [SAMPLE_BITS-1:0] cur_min,
	output logic signed [SAMPLE_BITS-1:0] cur_max,
	output logic signed [SAMPLE_BITS-1:0] tap_min,
	output logic signed [SAMPLE_BITS-1:0] tap_max
);

	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic                          hit;

	// merge the new sample into the neighbor's span, one deeper
	always_ff @(posedge clk) begin
		if (shift_en) begin
			min_q <= (sample < prev_min) ? sample : prev_min;
			max_q <= (sample > prev_max) ? sample : prev_max;
		end
	end

	assign cur_min = min_q;
	assign cur_max = max_q;

	// drive the result bus only when this depth is the window span
	assign hit     = (tap_idx == IW'(POS));
	assign tap_min = hit ? min_q : '0;
	assign tap_max = hit ? max_q : '0;

endmodule

// File: src/sliding_window_min_max_sum.sv
// Sliding window minimum and maximum with a running sum. Each accepted word carries one
// signed sample and a restart flag; each result word gives the minimum and maximum of the
// last window_size samples (fewer while the window fills), a full flag, and a 64-bit
// wrapping total of min plus max over all full windows since reset or restart. The block
// takes one sample per clock cycle unless the output stalls. The rate is set by the chain of
// window cells: on every sample each cell merges the new sample into its neighbor's min
// and max in one compare, so once j+1 samples are in, cell j holds the extremes of the
// newest j+1 samples and the answer is one tap of the chain. The total then takes two
// more stages, a pair add and a 64-bit accumulate. The user writes window_size through
// window_size_we only while the block is idle, not enforced by the block. Zero acts as
// one and values above WINDOW_MAX act as WINDOW_MAX. No clearing is needed after reset.
module sliding_window_min_max_sum #(
	parameter int WINDOW_MAX  = swmm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 window_size_we,
	input  logic        [swmm_pkg::CFG_W-1:0]    window_size,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [swmm_pkg::PORT_W-1:0]   sample,
	input  logic                                 restart,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [swmm_pkg::PORT_W-1:0]   window_min,
	output logic signed [swmm_pkg::PORT_W-1:0]   window_max,
	output logic                                 window_full,
	output logic signed [swmm_pkg::SUM_W-1:0]    running_sum
);

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int KW = (CW > swmm_pkg::CFG_W) ? CW : swmm_pkg::CFG_W;
	localparam int SB = SAMPLE_BITS;

	// configuration and fill state
	logic [swmm_pkg::CFG_W-1:0] ws_q;
	logic [CW-1:0]              fill_q;

	// control for the word entering the chain
	logic          accept;
	logic [KW-1:0] ws_ext;
	logic [KW-1:0] k_ext;
	logic [CW-1:0] k;
	logic [CW-1:0] fill_base;
	logic [CW-1:0] fill_nx;
	logic          full_nx;
	logic [CW-1:0] span;
	logic [CW-1:0] span_m1;
	logic signed [SB-1:0] s_in;

	// stage ready chain
	logic r1, r2, r3, r4;

	// stage registers
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [IW-1:0] idx_s1;
	logic          full_s1, full_s2, full_s3, full_s4;
	logic          rst_s1, rst_s2, rst_s3;
	logic signed [SB-1:0] mn_s2, mx_s2, mn_s3, mx_s3, mn_s4, mx_s4;
	logic signed [SB:0]   pair_s3;
	logic signed [swmm_pkg::SUM_W-1:0] total_q;
	logic signed [swmm_pkg::SUM_W-1:0] total_base;

	// chain wiring
	logic signed [SB-1:0] cur_min [WINDOW_MAX];
	logic signed [SB-1:0] cur_max [WINDOW_MAX];
	logic signed [SB-1:0] tap_min [WINDOW_MAX];
	logic signed [SB-1:0] tap_max [WINDOW_MAX];
	logic signed [SB-1:0] sel_min;
	logic signed [SB-1:0] sel_max;

	// handshake: bubbles collapse, each stage moves when the next can take it
	assign r4           = !vld_s4 || !result_stall;
	assign r3           = !vld_s3 || r4;
	assign r2           = !vld_s2 || r3;
	assign r1           = !vld_s1 || r2;
	assign sample_stall = !r1;
	assign accept       = sample_valid && r1;

	assign s_in = sample[SB-1:0];

	// window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= swmm_pkg::WS_RESET;
		end else if (window_size_we) begin
			ws_q <= window_size;
		end
	end

	// effective window length, fill count and tap select for the incoming word
	always_comb begin
		ws_ext = KW'(ws_q);
		if (ws_ext == '0) begin
			k_ext = KW'(1);
		end else if (ws_ext > KW'(WINDOW_MAX)) begin
			k_ext = KW'(WINDOW_MAX);
		end else begin
			k_ext = ws_ext;
		end
		k         = k_ext[CW-1:0];
		fill_base = restart ? '0 : fill_q;
		fill_nx   = (fill_base == CW'(WINDOW_MAX)) ? fill_base : fill_base + CW'(1);
		full_nx   = (fill_nx >= k);
		span      = full_nx ? k : fill_nx;
		span_m1   = span - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nx;
		end
	end

	// chain of window cells
	for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
		logic signed [SB-1:0] p_min;
		logic signed [SB-1:0] p_max;
		if (j == 0) begin : g_head
			assign p_min = s_in;
			assign p_max = s_in;
		end else begin : g_link
			assign p_min = cur_min[j-1];
			assign p_max = cur_max[j-1];
		end
		swmm_cell #(
			.SAMPLE_BITS(SB),
			.IW         (IW),
			.POS        (j)
		) u_cell (
			.clk     (clk),
			.shift_en(accept),
			.sample  (s_in),
			.prev_min(p_min),
			.prev_max(p_max),
			.tap_idx (idx_s1),
			.cur_min (cur_min[j]),
			.cur_max (cur_max[j]),
			.tap_min (tap_min[j]),
			.tap_max (tap_max[j])
		);
	end

	// gather the selected tap
	always_comb begin
		sel_min = '0;
		sel_max = '0;
		for (int j = 0; j < WINDOW_MAX; j++) begin
			sel_min = sel_min | tap_min[j];
			sel_max = sel_max | tap_max[j];
		end
	end

	// stage 1: word has updated the chain, tap index held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (r1) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1  <= span_m1[IW-1:0];
			full_s1 <= full_nx;
			rst_s1  <= restart;
		end
	end

	// stage 2: min and max read from the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (r2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && r2) begin
			mn_s2   <= sel_min;
			mx_s2   <= sel_max;
			full_s2 <= full_s1;
			rst_s2  <= rst_s1;
		end
	end

	// stage 3: min plus max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (r3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && r3) begin
			pair_s3 <= (SB+1)'(mn_s2) + (SB+1)'(mx_s2);
			mn_s3   <= mn_s2;
			mx_s3   <= mx_s2;
			full_s3 <= full_s2;
			rst_s3  <= rst_s2;
		end
	end

	// stage 4: running total and output word
	assign total_base = rst_s3 ? '0 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			total_q <= '0;
		end else begin
			if (r4) begin
				vld_s4 <= vld_s3;
			end
			if (vld_s3 && r4) begin
				total_q <= total_base +
					(full_s3 ? swmm_pkg::SUM_W'(pair_s3) : swmm_pkg::SUM_W'(0));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3 && r4) begin
			mn_s4   <= mn_s3;
			mx_s4   <= mx_s3;
			full_s4 <= full_s3;
		end
	end

	assign result_valid = vld_s4;
	assign window_min   = swmm_pkg::PORT_W'(mn_s4);
	assign window_max   = swmm_pkg::PORT_W'(mx_s4);
	assign window_full  = full_s4;
	assign running_sum  = total_q;

endmodule

// File: src/swmm_checker.sv
// port-level checks on the sliding window block
module swmm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_stall,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic signed [swmm_pkg::PORT_W-1:0] window_min,
	input logic signed [swmm_pkg::PORT_W-1:0] window_max,
	input logic                               window_full,
	input logic signed [swmm_pkg::SUM_W-1:0]  running_sum
);

	logic signed [swmm_pkg::SUM_W-1:0] last_sum_q;

	// total of the last delivered result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sum_q <= '0;
		end else if (result_valid && !result_stall) begin
			last_sum_q <= running_sum;
		end
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(window_min) &&
			$stable(window_max) && $stable(window_full) && $stable(running_sum)))
		else $error("stalled result word changed");

	// with no result waiting the pipeline always has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid) |-> (!sample_stall))
		else $error("input stalled with empty output");

	// the window minimum never exceeds the maximum
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (window_min <= window_max))
		else $error("window min above window max");

	// a partial window leaves the total alone, unless a restart cleared it
	a_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !window_full && sample_valid) |->
			(running_sum == last_sum_q || running_sum == '0))
		else $error("total moved on a partial window");

	// a lone result word also keeps the total on a partial window
	a_partial_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !window_full && !sample_valid) |->
			(running_sum == last_sum_q || running_sum == '0))
		else $error("total moved on a partial window");

endmodule

bind sliding_window_min_max_sum swmm_checker u_swmm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_valid(sample_valid),
	.sample_stall(sample_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.window_min  (window_min),
	.window_max  (window_max),
	.window_full (window_full),
	.running_sum (running_sum)
);
